// ----- rtl/rcvp_pkg.sv -----
// Shared types, constants, clip_axis and div_step for the rectangle clip and viewport mapping.
package rcvp_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned LEN_W   = 12;
    localparam int unsigned PROD_W  = 2 * LEN_W;
    localparam int unsigned DIV_STEPS = LEN_W;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_LEFT    = 3'd0,
        CFG_WIN_TOP     = 3'd1,
        CFG_WIN_WIDTH   = 3'd2,
        CFG_WIN_HEIGHT  = 3'd3,
        CFG_VIEW_LEFT   = 3'd4,
        CFG_VIEW_TOP    = 3'd5,
        CFG_VIEW_WIDTH  = 3'd6,
        CFG_VIEW_HEIGHT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] win_left;
        logic signed [POS_W-1:0] win_top;
        logic [LEN_W-1:0]        win_width;
        logic [LEN_W-1:0]        win_height;
        logic signed [POS_W-1:0] view_left;
        logic signed [POS_W-1:0] view_top;
        logic [LEN_W-1:0]        view_width;
        logic [LEN_W-1:0]        view_height;
    } t_cfg;

    // Classified item: offsets from the window origin and clipped extents.
    typedef struct packed {
        logic             visible;
        logic [LEN_W-1:0] xoff;
        logic [LEN_W-1:0] yoff;
        logic [LEN_W-1:0] cw;
        logic [LEN_W-1:0] ch;
    } t_cls;

    typedef struct packed {
        logic             ok;
        logic [LEN_W-1:0] off;
        logic [LEN_W-1:0] len;
    } t_axis;

    typedef struct packed {
        logic             q;
        logic [LEN_W-1:0] rem;
    } t_div_step;

    // Clip one axis; off and len are zero when the overlap is empty.
    function automatic t_axis clip_axis(input logic signed [POS_W-1:0] pos,
                                        input logic [LEN_W-1:0]        len,
                                        input logic signed [POS_W-1:0] wpos,
                                        input logic [LEN_W-1:0]        wlen);
        logic signed [POS_W+1:0] lo_r;
        logic signed [POS_W+1:0] lo_w;
        logic signed [POS_W+1:0] hi_r;
        logic signed [POS_W+1:0] hi_w;
        logic signed [POS_W+1:0] lo;
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] span;
        logic signed [POS_W+1:0] off;
        t_axis res;
        lo_r = $signed({{2{pos[POS_W-1]}}, pos});
        lo_w = $signed({{2{wpos[POS_W-1]}}, wpos});
        hi_r = lo_r + $signed({6'b0, len});
        hi_w = lo_w + $signed({6'b0, wlen});
        lo   = (lo_r > lo_w) ? lo_r : lo_w;
        hi   = (hi_r < hi_w) ? hi_r : hi_w;
        span = hi - lo;
        off  = lo - lo_w;
        // a zero window length leaves hi at or below lo, so it never passes
        res.ok  = (span > 0);
        res.off = res.ok ? off[LEN_W-1:0] : '0;
        res.len = res.ok ? span[LEN_W-1:0] : '0;
        return res;
    endfunction

    // One restoring division step; rem stays below the divisor.
    function automatic t_div_step div_step(input logic [LEN_W-1:0] rem,
                                           input logic             b,
                                           input logic [LEN_W-1:0] d);
        logic [LEN_W:0] t;
        logic [LEN_W:0] diff;
        t_div_step res;
        t    = {rem, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            res.q   = 1'b1;
            res.rem = diff[LEN_W-1:0];
        end else begin
            res.q   = 1'b0;
            res.rem = t[LEN_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/rcvp_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, dividend below divisor times 2^12.
module rcvp_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rcvp_pkg::PROD_W-1:0]  i_dividend,
    input  logic [rcvp_pkg::LEN_W-1:0]   i_divisor,
    output logic [rcvp_pkg::LEN_W-1:0]   o_quot
);

    localparam int unsigned LW = rcvp_pkg::LEN_W;
    localparam int unsigned NS = rcvp_pkg::DIV_STEPS;

    // lq holds the unused dividend bits on top and the quotient bits shifting in below
    logic [LW-1:0] r_rem [NS-1];
    logic [LW-1:0] r_lq  [NS];
    logic [LW-1:0] w_rem_in [NS];
    logic [LW-1:0] w_lq_in  [NS];
    rcvp_pkg::t_div_step w_step [NS];

    assign w_rem_in[0] = i_dividend[rcvp_pkg::PROD_W-1:LW];
    assign w_lq_in[0]  = i_dividend[LW-1:0];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        if (s > 0) begin : g_link
            assign w_rem_in[s] = r_rem[s-1];
            assign w_lq_in[s]  = r_lq[s-1];
        end

        assign w_step[s] = rcvp_pkg::div_step(w_rem_in[s], w_lq_in[s][LW-1], i_divisor);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lq[s] <= {w_lq_in[s][LW-2:0], w_step[s].q};
            end
        end

        if (s < NS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_step[s].rem;
                end
            end
        end
    end

    assign o_quot = r_lq[NS-1];

endmodule

// ----- rtl/rcvp_front.sv -----
// Front end: accepts rectangles, clips them against the window and classifies visibility.
module rcvp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rcvp_pkg::t_cfg                 i_cfg,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic signed [rcvp_pkg::POS_W-1:0] i_rect_left,
    input  logic signed [rcvp_pkg::POS_W-1:0] i_rect_top,
    input  logic [rcvp_pkg::LEN_W-1:0]     i_rect_width,
    input  logic [rcvp_pkg::LEN_W-1:0]     i_rect_height,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output rcvp_pkg::t_cls                 o_q_item
);

    logic           r_vld;
    rcvp_pkg::t_cls r_item;
    rcvp_pkg::t_axis w_ax;
    rcvp_pkg::t_axis w_ay;
    rcvp_pkg::t_cls  n_item;
    logic           w_adv;
    logic           w_acc;

    assign w_ax = rcvp_pkg::clip_axis(i_rect_left, i_rect_width,
                                      i_cfg.win_left, i_cfg.win_width);
    assign w_ay = rcvp_pkg::clip_axis(i_rect_top, i_rect_height,
                                      i_cfg.win_top, i_cfg.win_height);

    always_comb begin
        n_item.visible = w_ax.ok && w_ay.ok;
        // invisible items carry zeros so the divider sees a zero dividend
        n_item.xoff = n_item.visible ? w_ax.off : '0;
        n_item.cw   = n_item.visible ? w_ax.len : '0;
        n_item.yoff = n_item.visible ? w_ay.off : '0;
        n_item.ch   = n_item.visible ? w_ay.len : '0;
    end

    assign w_adv    = !r_vld || !i_q_full;
    assign o_full   = !w_adv;
    assign w_acc    = i_push && w_adv;
    assign o_q_push = r_vld && !i_q_full;
    assign o_q_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/rcvp_queue.sv -----
// Short queue of classified items between the front end and the mapping pipeline.
module rcvp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcvp_pkg::t_cls i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output rcvp_pkg::t_cls o_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rcvp_pkg::t_cls r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    assign n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("item pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("item popped from an empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count) + CNT_W'($past(i_push))
                                    - CNT_W'($past(i_pop)))
        else $error("queue count out of step with push and pop");
`endif

endmodule

// ----- rtl/rcvp_back.sv -----
// Back end: scales clipped offsets into the viewport through multipliers and pipelined dividers.
module rcvp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rcvp_pkg::t_cfg                    i_cfg,
    input  logic                              i_q_empty,
    input  rcvp_pkg::t_cls                    i_q_item,
    output logic                              o_q_pop,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic signed [rcvp_pkg::POS_W-1:0] o_out_left,
    output logic signed [rcvp_pkg::POS_W-1:0] o_out_top,
    output logic [rcvp_pkg::LEN_W-1:0]        o_out_width,
    output logic [rcvp_pkg::LEN_W-1:0]        o_out_height,
    output logic                              o_visible
);

    localparam int unsigned LW = rcvp_pkg::LEN_W;
    localparam int unsigned PW = rcvp_pkg::PROD_W;
    localparam int unsigned NS = rcvp_pkg::DIV_STEPS;

    logic          w_en;
    logic          r_m_vld;
    logic          r_m_vis;
    logic [PW-1:0] r_px;
    logic [PW-1:0] r_py;
    logic [PW-1:0] r_pw;
    logic [PW-1:0] r_ph;
    logic [NS-1:0] r_vld_sr;
    logic [NS-1:0] r_vis_sr;
    logic [LW-1:0] w_qx;
    logic [LW-1:0] w_qy;
    logic [LW-1:0] w_qw;
    logic [LW-1:0] w_qh;
    logic          r_out_vld;
    logic          r_out_vis;
    logic signed [rcvp_pkg::POS_W-1:0] r_out_left;
    logic signed [rcvp_pkg::POS_W-1:0] r_out_top;
    logic [LW-1:0] r_out_width;
    logic [LW-1:0] r_out_height;

    // whole pipeline moves together whenever the output slot can take an item
    assign w_en    = !r_out_vld || i_pop;
    assign o_q_pop = w_en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_vld_sr  <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld   <= !i_q_empty;
            r_vld_sr  <= {r_vld_sr[NS-2:0], r_m_vld};
            r_out_vld <= r_vld_sr[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_vis  <= i_q_item.visible;
            r_px     <= PW'(i_cfg.view_width)  * PW'(i_q_item.xoff);
            r_pw     <= PW'(i_cfg.view_width)  * PW'(i_q_item.cw);
            r_py     <= PW'(i_cfg.view_height) * PW'(i_q_item.yoff);
            r_ph     <= PW'(i_cfg.view_height) * PW'(i_q_item.ch);
            r_vis_sr <= {r_vis_sr[NS-2:0], r_m_vis};
            r_out_vis <= r_vis_sr[NS-1];
            if (r_vis_sr[NS-1]) begin
                r_out_left   <= i_cfg.view_left + $signed({4'b0, w_qx});
                r_out_top    <= i_cfg.view_top  + $signed({4'b0, w_qy});
                r_out_width  <= w_qw;
                r_out_height <= w_qh;
            end else begin
                r_out_left   <= '0;
                r_out_top    <= '0;
                r_out_width  <= '0;
                r_out_height <= '0;
            end
        end
    end

    rcvp_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r_px),
        .i_divisor  (i_cfg.win_width),
        .o_quot     (w_qx)
    );

    rcvp_div u_div_w (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r_pw),
        .i_divisor  (i_cfg.win_width),
        .o_quot     (w_qw)
    );

    rcvp_div u_div_y (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r_py),
        .i_divisor  (i_cfg.win_height),
        .o_quot     (w_qy)
    );

    rcvp_div u_div_h (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_dividend (r_ph),
        .i_divisor  (i_cfg.win_height),
        .o_quot     (w_qh)
    );

    assign o_empty      = !r_out_vld;
    assign o_out_left   = r_out_left;
    assign o_out_top    = r_out_top;
    assign o_out_width  = r_out_width;
    assign o_out_height = r_out_height;
    assign o_visible    = r_out_vis;

`ifndef SYNTHESIS
    a_hidden_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_vis) |-> (r_out_width == '0 && r_out_height == '0
                                       && r_out_left == '0 && r_out_top == '0))
        else $error("invisible item with non-zero rectangle");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_pop) |=> (r_out_vld && $stable(r_vld_sr) && $stable(r_m_vld)))
        else $error("pipeline moved while the output was stalled");

    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> w_en)
        else $error("queue popped while the pipeline was stalled");
`endif

endmodule

// ----- rtl/rect_clip_window_to_viewport_unit.sv -----
// Top level: configuration registers, clipping front end, item queue and viewport mapping back end.
//
// Takes one rectangle (left, top, width, height; right and bottom edges exclusive),
// clips it against the window register set and maps the clipped part into the
// viewport with exact floor(view * offset / window) scaling per axis.
// Input side: an item goes in on an edge with push high and full low.
// Result side: the oldest result sits on the o_ ports while empty is low and
// leaves on an edge with pop high and empty low.
// One result per item, in order. Throughput is one item per cycle while pop keeps
// the output free; an item passes from acceptance to empty falling through the clip
// stage, queue, multiply stage, 12-stage divider pipelines and output register.
// Empty intersections and zero window extents give visible low and zero fields.
// When pop is held low the back end freezes; the queue (QUEUE_DEPTH items) then
// the front register fill, and full rises once both are occupied. Reset
// (synchronous, i_rst_n low) empties the block and loads the register defaults: origins
// zero, extents one. The user writes registers only while idle; the block does not check.
module rect_clip_window_to_viewport_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rcvp_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [rcvp_pkg::POS_W-1:0]            i_cfg_wdata,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [rcvp_pkg::POS_W-1:0]     i_rect_left,
    input  logic signed [rcvp_pkg::POS_W-1:0]     i_rect_top,
    input  logic [rcvp_pkg::LEN_W-1:0]            i_rect_width,
    input  logic [rcvp_pkg::LEN_W-1:0]            i_rect_height,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [rcvp_pkg::POS_W-1:0]     o_out_left,
    output logic signed [rcvp_pkg::POS_W-1:0]     o_out_top,
    output logic [rcvp_pkg::LEN_W-1:0]            o_out_width,
    output logic [rcvp_pkg::LEN_W-1:0]            o_out_height,
    output logic                                  o_visible
);

    localparam int unsigned LW = rcvp_pkg::LEN_W;

    rcvp_pkg::t_cfg r_cfg;
    logic           w_q_push;
    logic           w_q_full;
    logic           w_q_pop;
    logic           w_q_empty;
    rcvp_pkg::t_cls w_f_item;
    rcvp_pkg::t_cls w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_left    <= '0;
            r_cfg.win_top     <= '0;
            r_cfg.win_width   <= LW'(1);
            r_cfg.win_height  <= LW'(1);
            r_cfg.view_left   <= '0;
            r_cfg.view_top    <= '0;
            r_cfg.view_width  <= LW'(1);
            r_cfg.view_height <= LW'(1);
        end else if (i_cfg_we) begin
            unique case (rcvp_pkg::t_cfg_idx'(i_cfg_addr))
                rcvp_pkg::CFG_WIN_LEFT:    r_cfg.win_left    <= $signed(i_cfg_wdata);
                rcvp_pkg::CFG_WIN_TOP:     r_cfg.win_top     <= $signed(i_cfg_wdata);
                rcvp_pkg::CFG_WIN_WIDTH:   r_cfg.win_width   <= i_cfg_wdata[LW-1:0];
                rcvp_pkg::CFG_WIN_HEIGHT:  r_cfg.win_height  <= i_cfg_wdata[LW-1:0];
                rcvp_pkg::CFG_VIEW_LEFT:   r_cfg.view_left   <= $signed(i_cfg_wdata);
                rcvp_pkg::CFG_VIEW_TOP:    r_cfg.view_top    <= $signed(i_cfg_wdata);
                rcvp_pkg::CFG_VIEW_WIDTH:  r_cfg.view_width  <= i_cfg_wdata[LW-1:0];
                rcvp_pkg::CFG_VIEW_HEIGHT: r_cfg.view_height <= i_cfg_wdata[LW-1:0];
            endcase
        end
    end

    rcvp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .o_full        (full),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_item      (w_f_item)
    );

    rcvp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_f_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    rcvp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_empty    (w_q_empty),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_left   (o_out_left),
        .o_out_top    (o_out_top),
        .o_out_width  (o_out_width),
        .o_out_height (o_out_height),
        .o_visible    (o_visible)
    );

endmodule

// ----- bench/tb_rect_clip_window_to_viewport_unit.sv -----
// Self-checking bench for the rectangle clip and viewport mapping unit.
module tb_rect_clip_window_to_viewport_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic signed [rcvp_pkg::POS_W-1:0] left;
        logic signed [rcvp_pkg::POS_W-1:0] top;
        logic [rcvp_pkg::LEN_W-1:0]        width;
        logic [rcvp_pkg::LEN_W-1:0]        height;
    } t_rect;

    typedef struct packed {
        logic signed [rcvp_pkg::POS_W-1:0] left;
        logic signed [rcvp_pkg::POS_W-1:0] top;
        logic [rcvp_pkg::LEN_W-1:0]        width;
        logic [rcvp_pkg::LEN_W-1:0]        height;
        logic                              visible;
    } t_mapped;

    logic                              i_clk;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [rcvp_pkg::CFG_IDX_W-1:0]    i_cfg_addr = '0;
    logic [rcvp_pkg::POS_W-1:0]        i_cfg_wdata = '0;
    logic                              push = 1'b0;
    logic                              full;
    logic signed [rcvp_pkg::POS_W-1:0] i_rect_left = '0;
    logic signed [rcvp_pkg::POS_W-1:0] i_rect_top = '0;
    logic [rcvp_pkg::LEN_W-1:0]        i_rect_width = '0;
    logic [rcvp_pkg::LEN_W-1:0]        i_rect_height = '0;
    logic                              empty;
    logic                              pop = 1'b0;
    logic signed [rcvp_pkg::POS_W-1:0] o_out_left;
    logic signed [rcvp_pkg::POS_W-1:0] o_out_top;
    logic [rcvp_pkg::LEN_W-1:0]        o_out_width;
    logic [rcvp_pkg::LEN_W-1:0]        o_out_height;
    logic                              o_visible;

    t_rect          rect_pending[$];
    t_mapped        mapped_due[$];
    rcvp_pkg::t_cfg cfg_now;
    t_rect          next_rect;
    t_mapped        got_due;
    logic    item_taken = 1'b0;
    int      n_in = 0;
    int      errors = 0;
    int      stall_cycles = 0;
    int      hold_left = 0;
    bit      long_hold_done = 1'b0;
    logic    calm;

    // both sides run flat out for a stretch in the middle of the run
    assign calm = (n_in >= 700 && n_in < 900);

    rect_clip_window_to_viewport_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .push          (push),
        .full          (full),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .empty         (empty),
        .pop           (pop),
        .o_out_left    (o_out_left),
        .o_out_top     (o_out_top),
        .o_out_width   (o_out_width),
        .o_out_height  (o_out_height),
        .o_visible     (o_visible)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Clip against the window, then scale the clipped part into the viewport.
    function automatic t_mapped map_rect(t_rect r, rcvp_pkg::t_cfg c);
        longint rl, rt, rw, rh, wl, wt, ww, wh, vl, vt, vw, vh;
        longint lo_x, hi_x, lo_y, hi_y;
        t_mapped m;
        m  = '0;
        rl = r.left;       rt = r.top;
        rw = r.width;      rh = r.height;
        wl = c.win_left;   wt = c.win_top;
        ww = c.win_width;  wh = c.win_height;
        vl = c.view_left;  vt = c.view_top;
        vw = c.view_width; vh = c.view_height;
        lo_x = (rl > wl) ? rl : wl;
        hi_x = (rl + rw < wl + ww) ? rl + rw : wl + ww;
        lo_y = (rt > wt) ? rt : wt;
        hi_y = (rt + rh < wt + wh) ? rt + rh : wt + wh;
        if (ww == 0 || wh == 0 || hi_x <= lo_x || hi_y <= lo_y)
            return m;
        m.left    = 16'(vl + vw * (lo_x - wl) / ww);
        m.top     = 16'(vt + vh * (lo_y - wt) / wh);
        m.width   = 12'(vw * (hi_x - lo_x) / ww);
        m.height  = 12'(vh * (hi_y - lo_y) / wh);
        m.visible = 1'b1;
        return m;
    endfunction

    function automatic rcvp_pkg::t_cfg make_cfg(logic [15:0] wl, logic [15:0] wt,
                                                logic [11:0] ww, logic [11:0] wh,
                                                logic [15:0] vl, logic [15:0] vt,
                                                logic [11:0] vw, logic [11:0] vh);
        rcvp_pkg::t_cfg c;
        c.win_left   = wl;
        c.win_top    = wt;
        c.win_width  = ww;
        c.win_height = wh;
        c.view_left  = vl;
        c.view_top   = vt;
        c.view_width = vw;
        c.view_height = vh;
        return c;
    endfunction

    function automatic logic [rcvp_pkg::LEN_W-1:0] pick_len();
        case ($urandom_range(3))
            0: return 12'd4095;
            1: return 12'($urandom_range(16, 1));
            default: return 12'($urandom_range(4095, 1));
        endcase
    endfunction

    // positions that sit exactly on or next to a window edge
    function automatic longint edge_pos(longint wpos, longint wlen, longint len);
        case ($urandom_range(4))
            0: return wpos - len;
            1: return wpos + wlen;
            2: return wpos;
            3: return wpos + wlen - 1;
            default: return wpos - 1;
        endcase
    endfunction

    function automatic t_rect random_rect(rcvp_pkg::t_cfg c);
        t_rect r;
        int unsigned p;
        longint wl, wt, ww, wh, rw, rh, lx, ly;
        p  = $urandom_range(99);
        wl = c.win_left;  wt = c.win_top;
        ww = c.win_width; wh = c.win_height;
        if (p < 15) begin
            r.left   = 16'($urandom);
            r.top    = 16'($urandom);
            r.width  = 12'($urandom);
            r.height = 12'($urandom);
            return r;
        end
        rw = $urandom_range(1) ? $urandom_range(4095) : $urandom_range(64);
        rh = $urandom_range(1) ? $urandom_range(4095) : $urandom_range(64);
        if (p < 30) begin
            lx = edge_pos(wl, ww, rw);
            ly = edge_pos(wt, wh, rh);
        end else begin
            // anywhere from just touching the near edge to just touching the far one
            lx = wl - rw + $urandom_range(int'(ww + rw));
            ly = wt - rh + $urandom_range(int'(wh + rh));
        end
        r.left   = 16'(lx);
        r.top    = 16'(ly);
        r.width  = 12'(rw);
        r.height = 12'(rh);
        return r;
    endfunction

    // appends one item to the sender's backlog
    task automatic queue_rect(t_rect r);
        rect_pending.insert(rect_pending.size(), r);
    endtask

    task automatic write_reg(rcvp_pkg::t_cfg_idx idx, logic [rcvp_pkg::POS_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
    endtask

    // Extent registers get junk in the unused top bits, which must be dropped.
    task automatic apply_cfg(rcvp_pkg::t_cfg c);
        write_reg(rcvp_pkg::CFG_WIN_LEFT, c.win_left);
        write_reg(rcvp_pkg::CFG_WIN_TOP, c.win_top);
        write_reg(rcvp_pkg::CFG_WIN_WIDTH, {4'($urandom), c.win_width});
        write_reg(rcvp_pkg::CFG_WIN_HEIGHT, {4'($urandom), c.win_height});
        write_reg(rcvp_pkg::CFG_VIEW_LEFT, c.view_left);
        write_reg(rcvp_pkg::CFG_VIEW_TOP, c.view_top);
        write_reg(rcvp_pkg::CFG_VIEW_WIDTH, {4'($urandom), c.view_width});
        write_reg(rcvp_pkg::CFG_VIEW_HEIGHT, {4'($urandom), c.view_height});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (rect_pending.size() != 0 || push || mapped_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [rcvp_pkg::POS_W-1:0] want,
                               logic [rcvp_pkg::POS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Sender: offers the next pending item once the current one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || item_taken) begin
            if (rect_pending.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
                next_rect = rect_pending.pop_front();
                push          <= 1'b1;
                i_rect_left   <= next_rect.left;
                i_rect_top    <= next_rect.top;
                i_rect_width  <= next_rect.width;
                i_rect_height <= next_rect.height;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up.
    always @(negedge i_clk) begin
        if (!long_hold_done && n_in >= 300 && rect_pending.size() > 60) begin
            hold_left = 250;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken   <= 1'b0;
            stall_cycles <= 0;
        end else begin
            item_taken <= push && !full;
            if (push && !full) begin
                mapped_due.insert(mapped_due.size(),
                                  map_rect({i_rect_left, i_rect_top, i_rect_width,
                                            i_rect_height}, cfg_now));
                n_in++;
            end
            if (pop && !empty) begin
                if (mapped_due.size() == 0) begin
                    $error("result with no item outstanding: left %0d top %0d vis %b",
                           o_out_left, o_out_top, o_visible);
                    errors++;
                end else begin
                    got_due = mapped_due.pop_front();
                    check_field("out_left", got_due.left, o_out_left);
                    check_field("out_top", got_due.top, o_out_top);
                    check_field("out_width", got_due.width, o_out_width);
                    check_field("out_height", got_due.height, o_out_height);
                    check_field("visible", got_due.visible, o_visible);
                end
            end
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else if (push || mapped_due.size() != 0 || rect_pending.size() != 0)
                stall_cycles <= stall_cycles + 1;
            else
                stall_cycles <= 0;
        end
    end

    initial begin
        do @(posedge i_clk);
        while (stall_cycles < STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        rcvp_pkg::t_cfg c;
        cfg_now = make_cfg(16'sd0, 16'sd0, 12'd1, 12'd1, 16'sd0, 16'sd0, 12'd1, 12'd1);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: a one pixel window at the origin
        queue_rect('{0, 0, 1, 1});
        queue_rect('{-5, -5, 10, 10});
        queue_rect('{1, 0, 3, 3});
        queue_rect('{0, 0, 0, 1});
        repeat (10) queue_rect(random_rect(cfg_now));

        wait_idle();
        c = make_cfg(-16'sd100, -16'sd50, 12'd200, 12'd150,
                     16'sd10, 16'sd20, 12'd640, 12'd480);
        apply_cfg(c);
        queue_rect('{-50, -20, 30, 40});        // fully inside
        queue_rect('{-120, -20, 50, 10});       // across the left edge
        queue_rect('{90, 0, 50, 10});           // across the right edge
        queue_rect('{0, -70, 10, 40});          // across the top edge
        queue_rect('{0, 90, 10, 40});           // across the bottom edge
        queue_rect('{-200, -200, 4095, 4095});  // covers the whole window
        queue_rect('{100, 0, 10, 10});          // starts on the exclusive right edge
        queue_rect('{-110, 0, 10, 10});         // ends on the left edge
        queue_rect('{0, 100, 5, 5});            // starts on the bottom edge
        queue_rect('{0, -60, 5, 10});           // ends on the top edge
        queue_rect('{0, 0, 0, 10});             // zero width
        queue_rect('{0, 0, 10, 0});             // zero height
        queue_rect('{-32768, -32768, 4095, 4095});
        queue_rect('{32767, 32767, 4095, 4095});
        queue_rect('{-100, -50, 1, 1});         // window origin pixel
        queue_rect('{99, 99, 1, 1});            // last window pixel
        queue_rect('{-32768, 0, 0, 4095});
        queue_rect('{32767, -32768, 4095, 0});
        repeat (90) queue_rect(random_rect(c));

        // extremes; the x position wraps past the top of the signed range
        wait_idle();
        c = make_cfg(16'h8000, 16'h8000, 12'd4095, 12'd4095,
                     16'h7fff, 16'h8000, 12'd4095, 12'd4095);
        apply_cfg(c);
        repeat (90) queue_rect(random_rect(c));

        wait_idle();
        c = make_cfg(16'h7fff, 16'h7fff, 12'd4095, 12'd4095,
                     16'h8000, 16'h7fff, 12'd1, 12'd4095);
        apply_cfg(c);
        repeat (90) queue_rect(random_rect(c));

        // zero window width, then zero window height
        wait_idle();
        c = make_cfg(16'sd0, 16'sd0, 12'd0, 12'd100, 16'sd0, 16'sd0, 12'd100, 12'd100);
        apply_cfg(c);
        repeat (40) queue_rect(random_rect(c));

        wait_idle();
        c = make_cfg(16'sd0, 16'sd0, 12'd100, 12'd0, 16'sd0, 16'sd0, 12'd100, 12'd100);
        apply_cfg(c);
        repeat (40) queue_rect(random_rect(c));

        // viewport too small for most results to keep any extent
        wait_idle();
        c = make_cfg(-16'sd500, -16'sd500, 12'd4095, 12'd3000,
                     16'sd5, 16'sd5, 12'd3, 12'd0);
        apply_cfg(c);
        repeat (90) queue_rect(random_rect(c));

        repeat (8) begin
            wait_idle();
            c = make_cfg(16'($urandom), 16'($urandom), pick_len(), pick_len(),
                         16'($urandom), 16'($urandom), pick_len(), pick_len());
            apply_cfg(c);
            repeat (85) queue_rect(random_rect(c));
        end

        wait_idle();
        repeat (30) @(negedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
